>>> design/vtyp_pkg.sv
`default_nettype none

package vtyp_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int COORD_WIDTH   = 24;
   localparam int GUARD_BITS    = 8;
   localparam int MAG_W         = COORD_WIDTH + GUARD_BITS;
   localparam int CW            = MAG_W + 3;
   localparam int AW            = 25;
   localparam int YAW_W         = 17;
   localparam int PITCH_W       = 16;
   localparam int GAIN_W        = 20;
   localparam int GAIN_FRAC     = 20;
   localparam int OUT_SHIFT     = 8;

   localparam logic [GAIN_W-1:0]    INV_GAIN   = GAIN_W'(636751);
   localparam logic signed [AW-1:0] ANG_90     = AW'(90 * 65536);
   localparam logic [AW-1:0]        ANG_180    = AW'(180 * 65536);
   localparam logic [AW-1:0]        ANG_360    = AW'(360 * 65536);
   localparam logic [YAW_W:0]       FULL_TURN  = (YAW_W + 1)'(92160);
   localparam logic signed [PITCH_W-1:0] PITCH_LIMIT = PITCH_W'(23040);

   localparam int ATAN_TABLE [32] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0,
      0, 0, 0, 0, 0, 0, 0, 0
   };

   typedef struct packed {
      logic [MAG_W-1:0] mz;
      logic             z_neg;
      logic             mz_zero;
      logic             ms_zero;
      logic             fwd_neg;
      logic             side_neg;
      logic             r_zero;
      logic [YAW_W-1:0] yaw;
   } side_type;

endpackage

`default_nettype wire

>>> design/vector_to_yaw_pitch.sv
`default_nettype none
// A request transfer reaches its response through one input stage, 16 yaw
// CORDIC stages, two gain-correction stages, 16 pitch CORDIC stages and one
// output stage. One vector is accepted every cycle unless a stall reaches the input;
// a stalled response holds only the stages behind it, and empty stages keep filling.
// Synchronous active-high reset clears all valid bits; data registers are not reset.

module vector_to_yaw_pitch (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [vtyp_pkg::COORD_WIDTH-1:0] req_dir_x,
   input  logic signed [vtyp_pkg::COORD_WIDTH-1:0] req_dir_y,
   input  logic signed [vtyp_pkg::COORD_WIDTH-1:0] req_dir_z,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [vtyp_pkg::YAW_W-1:0]              rsp_yaw,
   output logic signed [vtyp_pkg::PITCH_W-1:0]     rsp_pitch
);
   import vtyp_pkg::*;

   logic                     prep_valid_ff;
   logic                     prep_ready;
   logic signed [CW-1:0]     px_ff;
   logic signed [CW-1:0]     py_ff;
   side_type                 pside_ff;
   logic signed [CW-1:0]     px_in;
   logic signed [CW-1:0]     py_in;
   side_type                 pside_in;
   logic [COORD_WIDTH-1:0]   mag_x;
   logic [COORD_WIDTH-1:0]   mag_y;
   logic [COORD_WIDTH-1:0]   mag_z;

   logic                     yaw_ready;
   logic                     yaw_valid;
   logic signed [CW-1:0]     yaw_x;
   logic signed [AW-1:0]     yaw_ang;
   side_type                 yaw_side;

   logic                     gain_ready;
   logic                     gain_valid;
   logic signed [CW-1:0]     gain_r;
   side_type                 gain_side;
   logic signed [CW-1:0]     gain_mz;

   logic                     pitch_ready;
   logic                     pitch_valid;
   logic signed [CW-1:0]     pitch_x;
   logic signed [AW-1:0]     pitch_ang;
   side_type                 pitch_side;

   logic                     fin_ready;
   logic signed [AW-1:0]     p_clamp;
   logic [AW:0]              p_sum;
   logic [PITCH_W-1:0]       p_mag;
   logic [YAW_W-1:0]         rsp_yaw_ff;
   logic [YAW_W-1:0]         rsp_yaw_in;
   logic signed [PITCH_W-1:0] rsp_pitch_ff;
   logic signed [PITCH_W-1:0] rsp_pitch_in;
   logic                     rsp_valid_ff;

   assign prep_ready = !prep_valid_ff || yaw_ready;
   assign req_ready  = prep_ready;

   // Yaw is measured from the negative y axis, so the forward term is -y.
   always_comb begin
      mag_x = req_dir_x[COORD_WIDTH-1] ? COORD_WIDTH'(-req_dir_x) : req_dir_x;
      mag_y = req_dir_y[COORD_WIDTH-1] ? COORD_WIDTH'(-req_dir_y) : req_dir_y;
      mag_z = req_dir_z[COORD_WIDTH-1] ? COORD_WIDTH'(-req_dir_z) : req_dir_z;

      px_in = {{(CW - MAG_W){1'b0}}, mag_y, {GUARD_BITS{1'b0}}};
      py_in = {{(CW - MAG_W){1'b0}}, mag_x, {GUARD_BITS{1'b0}}};

      pside_in.mz       = {mag_z, {GUARD_BITS{1'b0}}};
      pside_in.z_neg    = req_dir_z[COORD_WIDTH-1];
      pside_in.mz_zero  = (req_dir_z == '0);
      pside_in.ms_zero  = (req_dir_x == '0);
      pside_in.fwd_neg  = !req_dir_y[COORD_WIDTH-1] && (req_dir_y != '0);
      pside_in.side_neg = req_dir_x[COORD_WIDTH-1];
      pside_in.r_zero   = 1'b0;
      pside_in.yaw      = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (prep_ready) begin
         prep_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (prep_ready && req_valid) begin
         px_ff    <= px_in;
         py_ff    <= py_in;
         pside_ff <= pside_in;
      end
   end

   vtyp_cordic u_yaw_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid_ff),
      .in_ready  (yaw_ready),
      .in_x      (px_ff),
      .in_y      (py_ff),
      .in_side   (pside_ff),
      .out_valid (yaw_valid),
      .out_ready (gain_ready),
      .out_x     (yaw_x),
      .out_ang   (yaw_ang),
      .out_side  (yaw_side)
   );

   vtyp_gain u_gain (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (yaw_valid),
      .in_ready  (gain_ready),
      .in_x      (yaw_x),
      .in_ang    (yaw_ang),
      .in_side   (yaw_side),
      .out_valid (gain_valid),
      .out_ready (pitch_ready),
      .out_r     (gain_r),
      .out_side  (gain_side)
   );

   assign gain_mz = {{(CW - MAG_W){1'b0}}, gain_side.mz};

   vtyp_cordic u_pitch_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (gain_valid),
      .in_ready  (pitch_ready),
      .in_x      (gain_r),
      .in_y      (gain_mz),
      .in_side   (gain_side),
      .out_valid (pitch_valid),
      .out_ready (fin_ready),
      .out_x     (pitch_x),
      .out_ang   (pitch_ang),
      .out_side  (pitch_side)
   );

   assign fin_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      if (pitch_side.mz_zero || pitch_ang[AW-1]) begin
         p_clamp = '0;
      end else if (pitch_side.r_zero || (pitch_ang > ANG_90)) begin
         p_clamp = ANG_90;
      end else begin
         p_clamp = pitch_ang;
      end

      p_sum        = {1'b0, p_clamp} + (AW + 1)'(1 << (OUT_SHIFT - 1));
      p_mag        = p_sum[OUT_SHIFT+PITCH_W-1:OUT_SHIFT];
      rsp_pitch_in = pitch_side.z_neg ? -$signed(p_mag) : $signed(p_mag);
      rsp_yaw_in   = pitch_side.yaw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_ready) begin
         rsp_valid_ff <= pitch_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_ready && pitch_valid) begin
         rsp_yaw_ff   <= rsp_yaw_in;
         rsp_pitch_ff <= rsp_pitch_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_yaw   = rsp_yaw_ff;
   assign rsp_pitch = rsp_pitch_ff;

`ifndef ASSERT_OFF
   a_yaw_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_yaw} < FULL_TURN))
      else $error("Yaw is outside one full turn.");

   a_pitch_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_pitch <= PITCH_LIMIT) && (rsp_pitch >= -PITCH_LIMIT)))
      else $error("Pitch is outside plus or minus ninety degrees.");

   a_pitch_mag : assert property (@(posedge clock) disable iff (reset)
      pitch_valid |-> !pitch_x[CW-1])
      else $error("Pitch vector length went negative.");

   a_flat_pitch : assert property (@(posedge clock) disable iff (reset)
      (fin_ready && pitch_valid && pitch_side.mz_zero) |=> (rsp_pitch == '0))
      else $error("A vector with no vertical part gave a nonzero pitch.");

   a_reset_clear : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("A response is valid right after reset.");
`endif

endmodule

`default_nettype wire

>>> design/vtyp_cordic.sv
`default_nettype none

module vtyp_cordic (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic signed [vtyp_pkg::CW-1:0]   in_x,
   input  logic signed [vtyp_pkg::CW-1:0]   in_y,
   input  vtyp_pkg::side_type               in_side,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic signed [vtyp_pkg::CW-1:0]   out_x,
   output logic signed [vtyp_pkg::AW-1:0]   out_ang,
   output vtyp_pkg::side_type               out_side
);
   import vtyp_pkg::*;

   logic [CORDIC_STAGES-1:0] valid_ff;
   logic [CORDIC_STAGES:0]   ready;
   logic signed [CW-1:0]     x_ff [CORDIC_STAGES];
   logic signed [CW-1:0]     y_ff [CORDIC_STAGES];
   logic signed [AW-1:0]     a_ff [CORDIC_STAGES];
   side_type                 side_ff [CORDIC_STAGES];
   logic signed [CW-1:0]     x_in [CORDIC_STAGES];
   logic signed [CW-1:0]     y_in [CORDIC_STAGES];
   logic signed [AW-1:0]     a_in [CORDIC_STAGES];

   // A stage may load when it is empty or when its content moves on.
   always_comb begin
      ready[CORDIC_STAGES] = out_ready;
      for (int k = CORDIC_STAGES - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      localparam logic signed [AW-1:0] ATAN_STEP = AW'(ATAN_TABLE[i]);
      logic signed [CW-1:0] x_src;
      logic signed [CW-1:0] y_src;
      logic signed [AW-1:0] a_src;
      logic                 v_src;
      side_type             s_src;

      if (i == 0) begin : g_first
         assign x_src = in_x;
         assign y_src = in_y;
         assign a_src = '0;
         assign v_src = in_valid;
         assign s_src = in_side;
      end else begin : g_next
         assign x_src = x_ff[i-1];
         assign y_src = y_ff[i-1];
         assign a_src = a_ff[i-1];
         assign v_src = valid_ff[i-1];
         assign s_src = side_ff[i-1];
      end

      always_comb begin
         if (!y_src[CW-1]) begin
            x_in[i] = x_src + (y_src >>> i);
            y_in[i] = y_src - (x_src >>> i);
            a_in[i] = a_src + ATAN_STEP;
         end else begin
            x_in[i] = x_src - (y_src >>> i);
            y_in[i] = y_src + (x_src >>> i);
            a_in[i] = a_src - ATAN_STEP;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (ready[i]) begin
            valid_ff[i] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (ready[i] && v_src) begin
            x_ff[i]    <= x_in[i];
            y_ff[i]    <= y_in[i];
            a_ff[i]    <= a_in[i];
            side_ff[i] <= s_src;
         end
      end
   end

   assign in_ready  = ready[0];
   assign out_valid = valid_ff[CORDIC_STAGES-1];
   assign out_x     = x_ff[CORDIC_STAGES-1];
   assign out_ang   = a_ff[CORDIC_STAGES-1];
   assign out_side  = side_ff[CORDIC_STAGES-1];

endmodule

`default_nettype wire

>>> design/vtyp_gain.sv
`default_nettype none

module vtyp_gain (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic signed [vtyp_pkg::CW-1:0]   in_x,
   input  logic signed [vtyp_pkg::AW-1:0]   in_ang,
   input  vtyp_pkg::side_type               in_side,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic signed [vtyp_pkg::CW-1:0]   out_r,
   output vtyp_pkg::side_type               out_side
);
   import vtyp_pkg::*;

   localparam int PW = CW - 1 + GAIN_W;
   localparam logic [PW:0] HALF = (PW + 1)'(1) << (GAIN_FRAC - 1);

   logic                   valid_a_ff;
   logic                   valid_b_ff;
   logic                   ready_a;
   logic                   ready_b;
   logic [PW-1:0]          prod_ff;
   logic [PW-1:0]          prod_in;
   side_type               side_a_ff;
   side_type               side_a_in;
   side_type               side_b_ff;
   side_type               side_b_in;
   logic signed [CW-1:0]   r_ff;
   logic signed [CW-1:0]   r_in;
   logic signed [AW-1:0]   ang_clamp;
   logic [AW-1:0]          quad_ang;
   logic [AW:0]            yaw_sum;
   logic [YAW_W:0]         yaw_rnd;
   logic [YAW_W:0]         yaw_wrap;
   logic [PW:0]            r_sum;
   logic [PW-GAIN_FRAC:0]  r_full;

   assign ready_b  = !valid_b_ff || out_ready;
   assign ready_a  = !valid_a_ff || ready_b;
   assign in_ready = ready_a;

   // The yaw angle is finished while the gain product is formed.
   always_comb begin
      prod_in = in_x[CW-2:0] * INV_GAIN;

      if (in_ang[AW-1] || in_side.ms_zero) begin
         ang_clamp = '0;
      end else if (in_ang > ANG_90) begin
         ang_clamp = ANG_90;
      end else begin
         ang_clamp = in_ang;
      end

      case ({in_side.fwd_neg, in_side.side_neg})
         2'b00:   quad_ang = ang_clamp;
         2'b10:   quad_ang = ANG_180 - ang_clamp;
         2'b11:   quad_ang = ANG_180 + ang_clamp;
         default: quad_ang = ANG_360 - ang_clamp;
      endcase

      yaw_sum = {1'b0, quad_ang} + (AW + 1)'(1 << (OUT_SHIFT - 1));
      yaw_rnd = yaw_sum[AW:OUT_SHIFT];
      if (yaw_rnd >= FULL_TURN) begin
         yaw_wrap = yaw_rnd - FULL_TURN;
      end else begin
         yaw_wrap = yaw_rnd;
      end

      side_a_in     = in_side;
      side_a_in.yaw = yaw_wrap[YAW_W-1:0];
   end

   always_comb begin
      r_sum            = {1'b0, prod_ff} + HALF;
      r_full           = r_sum[PW:GAIN_FRAC];
      r_in             = {1'b0, r_full[CW-2:0]};
      side_b_in        = side_a_ff;
      side_b_in.r_zero = (r_full == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         if (ready_a) begin
            valid_a_ff <= in_valid;
         end
         if (ready_b) begin
            valid_b_ff <= valid_a_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a && in_valid) begin
         prod_ff   <= prod_in;
         side_a_ff <= side_a_in;
      end
      if (ready_b && valid_a_ff) begin
         r_ff      <= r_in;
         side_b_ff <= side_b_in;
      end
   end

   assign out_valid = valid_b_ff;
   assign out_r     = r_ff;
   assign out_side  = side_b_ff;

endmodule

`default_nettype wire
